/* rtl/conv3x3_interior_filter_macros.svh */
// ----------------------------------------------------------------------------
// conv3x3_interior_filter_macros.svh
// Assertion macros used by the filter's port checker.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_INTERIOR_FILTER_MACROS_SVH
`define CONV3X3_INTERIOR_FILTER_MACROS_SVH

// Concurrent check on the rising clock, off while reset is high.
`define C3F_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("conv3x3 filter check failed");

// Concurrent check that also holds through reset.
`define C3F_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("conv3x3 filter reset check failed");

`endif

/* rtl/c3f_pkg.sv */
// ----------------------------------------------------------------------------
// c3f_pkg
// Types, constants and helpers of the 3x3 interior convolution filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int PIX_W       = 8;
   localparam int POS_W       = 12;
   localparam int DIM_W       = 13;
   localparam int COEF_W      = 16;
   localparam int KERNEL_SIZE = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = KERNEL_SIZE * COEF_W;
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MIN_DIM     = 3;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int FRAC_BITS   = 11;
   localparam int PIX_MAX     = 255;

   // Pixel (9 bit signed) times coefficient, three of them, then nine.
   localparam int PROD_W  = PIX_W + 1 + COEF_W;
   localparam int CSUM_W  = PROD_W + 2;
   localparam int SUM_W   = CSUM_W + 2;
   localparam int WHOLE_W = SUM_W - FRAC_BITS;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOT = 3'd4;

   localparam logic [DIM_W-1:0]      RST_WIDTH    = 13'd640;
   localparam logic [DIM_W-1:0]      RST_HEIGHT   = 13'd480;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_TOP = '0;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_MID = 48'd134217728;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_BOT = '0;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   // One window column: top, middle and bottom pixel
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } column_type;

   typedef struct packed {
      coef_type top;
      coef_type mid;
      coef_type bot;
   } coef_col_type;

   typedef struct packed {
      logic shift;
      logic advance;
   } cell_ctl_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
   } lb_ctl_type;

   // Floor the Q18.11 sum and clamp to the pixel range.
   function automatic pix_type clamp_pixel(input logic signed [SUM_W-1:0] s);
      logic [WHOLE_W-1:0] whole;
      whole = s[SUM_W-1:FRAC_BITS];
      if (s[SUM_W-1]) begin
         clamp_pixel = '0;
      end else if (whole > WHOLE_W'(PIX_MAX)) begin
         clamp_pixel = PIX_W'(PIX_MAX);
      end else begin
         clamp_pixel = whole[PIX_W-1:0];
      end
   endfunction

   // Saturate a frame dimension to MIN_DIM..hi.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
      if (v < DIM_W'(MIN_DIM)) begin
         clamp_dim = DIM_W'(MIN_DIM);
      end else if (v > hi) begin
         clamp_dim = hi;
      end else begin
         clamp_dim = v;
      end
   endfunction

endpackage

/* rtl/c3f_stream_ifs.sv */
// ----------------------------------------------------------------------------
// c3f_stream_ifs
// Valid/ready channels of the filter: source pixels in, filtered words out.
// ----------------------------------------------------------------------------
interface c3f_req_if;
   logic             valid;
   logic             ready;
   c3f_pkg::pix_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface c3f_rsp_if;
   logic                         valid;
   logic                         ready;
   c3f_pkg::pix_type             pixel_out;
   logic [c3f_pkg::POS_W-1:0]    out_row;
   logic [c3f_pkg::POS_W-1:0]    out_column;

   modport source (output valid, output pixel_out, output out_row, output out_column,
                   input ready);
   modport sink (input valid, input pixel_out, input out_row, input out_column,
                 output ready);
endinterface

/* rtl/c3f_cell.sv */
// ----------------------------------------------------------------------------
// c3f_cell
// One window column: holds three pixels, hands them to its left neighbor on
// each shift, and forms the column's weighted sum over two register stages.
// ----------------------------------------------------------------------------
module c3f_cell (
   input  logic                                clock,
   input  c3f_pkg::cell_ctl_type               ctl,
   input  c3f_pkg::column_type                 col_in,
   input  c3f_pkg::coef_col_type               coef,
   output c3f_pkg::column_type                 col_out,
   output logic signed [c3f_pkg::CSUM_W-1:0]   col_sum
);

   c3f_pkg::column_type                col_ff;
   logic signed [c3f_pkg::PROD_W-1:0]  pix_top_s, pix_mid_s, pix_bot_s;
   logic signed [c3f_pkg::PROD_W-1:0]  prod_top_in, prod_mid_in, prod_bot_in;
   logic signed [c3f_pkg::PROD_W-1:0]  prod_top_ff, prod_mid_ff, prod_bot_ff;
   logic signed [c3f_pkg::CSUM_W-1:0]  col_sum_in, col_sum_ff;

   assign pix_top_s = c3f_pkg::PROD_W'($signed({1'b0, col_ff.top}));
   assign pix_mid_s = c3f_pkg::PROD_W'($signed({1'b0, col_ff.mid}));
   assign pix_bot_s = c3f_pkg::PROD_W'($signed({1'b0, col_ff.bot}));

   assign prod_top_in = pix_top_s * c3f_pkg::PROD_W'(coef.top);
   assign prod_mid_in = pix_mid_s * c3f_pkg::PROD_W'(coef.mid);
   assign prod_bot_in = pix_bot_s * c3f_pkg::PROD_W'(coef.bot);

   assign col_sum_in = c3f_pkg::CSUM_W'(prod_top_ff) + c3f_pkg::CSUM_W'(prod_mid_ff)
                     + c3f_pkg::CSUM_W'(prod_bot_ff);

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         col_ff <= col_in;
      end
      if (ctl.advance) begin
         prod_top_ff <= prod_top_in;
         prod_mid_ff <= prod_mid_in;
         prod_bot_ff <= prod_bot_in;
         col_sum_ff  <= col_sum_in;
      end
   end

   assign col_out = col_ff;
   assign col_sum = col_sum_ff;

endmodule

/* rtl/c3f_line_buf.sv */
// ----------------------------------------------------------------------------
// c3f_line_buf
// Two line stores of one row each. Read at the incoming column, rotate the
// newer row into the older bank and the new pixel into the newer bank.
// ----------------------------------------------------------------------------
module c3f_line_buf (
   input  logic                   clock,
   input  c3f_pkg::lb_ctl_type    ctl,
   input  c3f_pkg::pix_type       wr_pix,
   output c3f_pkg::pix_type       above2,
   output c3f_pkg::pix_type       above1
);

   c3f_pkg::pix_type bank_old [c3f_pkg::MAX_WIDTH];
   c3f_pkg::pix_type bank_new [c3f_pkg::MAX_WIDTH];
   c3f_pkg::pix_type above2_ff, above1_ff;

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         above2_ff <= bank_old[ctl.rd_addr];
         above1_ff <= bank_new[ctl.rd_addr];
      end
   end

   // Write back the word read for the item now leaving the first stage
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bank_old[ctl.wr_addr] <= above1_ff;
         bank_new[ctl.wr_addr] <= wr_pix;
      end
   end

   assign above2 = above2_ff;
   assign above1 = above1_ff;

endmodule

/* rtl/conv3x3_interior_filter.sv */
// ----------------------------------------------------------------------------
// conv3x3_interior_filter
// 3x3 convolution over a raster pixel stream; emits interior pixels only.
// ----------------------------------------------------------------------------
//   channel   dir   word                               handshake
//   req_if    in    pixel_in                           valid / ready
//   rsp_if    out   pixel_out, out_row, out_column     valid / ready
//   csr_*     in    csr_index, csr_wdata               csr_wr_en, no wait
//
// One pixel per cycle unless input is held off. A pixel's result goes through
// the line store read, window shift, products and column sums, then the final
// add and clamp into the output register.
// Reset clears the counters and the stage valids; the line stores are not
// cleared. Input is held off only while the last stage has a word and the
// output register is full and not being taken.
// ----------------------------------------------------------------------------
module conv3x3_interior_filter (
   input  logic                                clock,
   input  logic                                reset,
   c3f_req_if.sink                             req_if,
   c3f_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [c3f_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c3f_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int KS = c3f_pkg::KERNEL_SIZE;

   typedef struct packed {
      logic                      emit;
      logic [c3f_pkg::POS_W-1:0] row;
      logic [c3f_pkg::POS_W-1:0] col;
   } tag_type;

   // Configuration
   logic [c3f_pkg::DIM_W-1:0]      width_ff, height_ff;
   logic [c3f_pkg::CSR_DATA_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;

   // Position counters
   logic [c3f_pkg::POS_W-1:0] column_count_ff, column_count_in;
   logic [c3f_pkg::POS_W-1:0] row_count_ff, row_count_in;

   logic [c3f_pkg::DIM_W-1:0] w_eff, h_eff, row_step, col_next;
   logic [c3f_pkg::POS_W-1:0] cur_col, cur_row, row_next;
   logic                      col_wrap;

   // Pipeline
   logic                      en, accept;
   logic                      v1_ff, emit1_ff;
   logic [c3f_pkg::POS_W-1:0] row1_ff, col1_ff;
   c3f_pkg::pix_type          pix1_ff;
   tag_type                   tag2_ff, tag3_ff, tag4_ff, tag2_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   c3f_pkg::pix_type          rsp_pix_ff;
   logic [c3f_pkg::POS_W-1:0] rsp_row_ff, rsp_col_ff;

   c3f_pkg::lb_ctl_type       lb_ctl;
   c3f_pkg::pix_type          above2, above1;
   c3f_pkg::cell_ctl_type     cell_ctl;
   c3f_pkg::column_type       col_q [KS];
   c3f_pkg::column_type       col_new;
   logic signed [c3f_pkg::CSUM_W-1:0] col_sum [KS];
   logic signed [c3f_pkg::SUM_W-1:0]  total;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= c3f_pkg::RST_WIDTH;
         height_ff   <= c3f_pkg::RST_HEIGHT;
         coef_top_ff <= c3f_pkg::RST_COEF_TOP;
         coef_mid_ff <= c3f_pkg::RST_COEF_MID;
         coef_bot_ff <= c3f_pkg::RST_COEF_BOT;
      end else if (csr_wr_en) begin
         case (csr_index)
            c3f_pkg::CSR_WIDTH: begin
               width_ff <= csr_wdata[c3f_pkg::DIM_W-1:0];
            end
            c3f_pkg::CSR_HEIGHT: begin
               height_ff <= csr_wdata[c3f_pkg::DIM_W-1:0];
            end
            c3f_pkg::CSR_COEF_TOP: begin
               coef_top_ff <= csr_wdata;
            end
            c3f_pkg::CSR_COEF_MID: begin
               coef_mid_ff <= csr_wdata;
            end
            c3f_pkg::CSR_COEF_BOT: begin
               coef_bot_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign w_eff = c3f_pkg::clamp_dim(width_ff, c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH));
   assign h_eff = c3f_pkg::clamp_dim(height_ff, c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT));

   // Position of the arriving pixel, re-wrapped against the current bounds
   assign col_wrap = {1'b0, column_count_ff} >= w_eff;
   assign row_step = col_wrap ? ({1'b0, row_count_ff} + c3f_pkg::DIM_W'(1))
                              : {1'b0, row_count_ff};
   assign cur_col  = col_wrap ? '0 : column_count_ff;
   assign cur_row  = (row_step >= h_eff) ? '0 : row_step[c3f_pkg::POS_W-1:0];

   // Position of the next pixel
   assign col_next = {1'b0, cur_col} + c3f_pkg::DIM_W'(1);
   assign row_next = ({1'b0, cur_row} + c3f_pkg::DIM_W'(1) >= h_eff) ? '0
                   : cur_row + c3f_pkg::POS_W'(1);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            column_count_in = '0;
            row_count_in    = row_next;
         end else begin
            column_count_in = col_next[c3f_pkg::POS_W-1:0];
            row_count_in    = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Stall only when the last stage has a word and the output cannot take it
   assign en     = !(tag4_ff.emit && rsp_valid_ff && !rsp_if.ready);
   assign accept = req_if.valid && en;
   assign req_if.ready = en;

   assign lb_ctl.rd_en   = accept;
   assign lb_ctl.rd_addr = cur_col[c3f_pkg::ADDR_W-1:0];
   assign lb_ctl.wr_en   = en && v1_ff;
   assign lb_ctl.wr_addr = col1_ff[c3f_pkg::ADDR_W-1:0];

   c3f_line_buf u_line_buf (
      .clock  (clock),
      .ctl    (lb_ctl),
      .wr_pix (pix1_ff),
      .above2 (above2),
      .above1 (above1)
   );

   assign tag2_in.emit = v1_ff && emit1_ff;
   assign tag2_in.row  = row1_ff - c3f_pkg::POS_W'(1);
   assign tag2_in.col  = col1_ff - c3f_pkg::POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         tag2_ff.emit <= 1'b0;
         tag3_ff.emit <= 1'b0;
         tag4_ff.emit <= 1'b0;
      end else if (en) begin
         v1_ff        <= accept;
         tag2_ff.emit <= tag2_in.emit;
         tag3_ff.emit <= tag2_ff.emit;
         tag4_ff.emit <= tag3_ff.emit;
      end
      if (en) begin
         emit1_ff    <= (cur_row >= c3f_pkg::POS_W'(2)) && (cur_col >= c3f_pkg::POS_W'(2));
         row1_ff     <= cur_row;
         col1_ff     <= cur_col;
         pix1_ff     <= req_if.pixel_in;
         tag2_ff.row <= tag2_in.row;
         tag2_ff.col <= tag2_in.col;
         tag3_ff.row <= tag2_ff.row;
         tag3_ff.col <= tag2_ff.col;
         tag4_ff.row <= tag3_ff.row;
         tag4_ff.col <= tag3_ff.col;
      end
   end

   // Window: newest column enters on the right and moves left
   assign cell_ctl.shift   = en && v1_ff;
   assign cell_ctl.advance = en;
   assign col_new.top = above2;
   assign col_new.mid = above1;
   assign col_new.bot = pix1_ff;

   for (genvar j = 0; j < KS; j++) begin : g_cell
      c3f_pkg::coef_col_type cell_coef;
      c3f_pkg::column_type   cell_in;

      assign cell_coef.top = coef_top_ff[c3f_pkg::COEF_W*j +: c3f_pkg::COEF_W];
      assign cell_coef.mid = coef_mid_ff[c3f_pkg::COEF_W*j +: c3f_pkg::COEF_W];
      assign cell_coef.bot = coef_bot_ff[c3f_pkg::COEF_W*j +: c3f_pkg::COEF_W];
      assign cell_in = (j == KS - 1) ? col_new : col_q[(j + 1) % KS];

      c3f_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .col_in  (cell_in),
         .coef    (cell_coef),
         .col_out (col_q[j]),
         .col_sum (col_sum[j])
      );
   end

   always_comb begin
      total = '0;
      for (int j = 0; j < KS; j++) begin
         total = total + c3f_pkg::SUM_W'(col_sum[j]);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (en && tag4_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tag4_ff.emit) begin
         rsp_pix_ff <= c3f_pkg::clamp_pixel(total);
         rsp_row_ff <= tag4_ff.row;
         rsp_col_ff <= tag4_ff.col;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_out  = rsp_pix_ff;
   assign rsp_if.out_row    = rsp_row_ff;
   assign rsp_if.out_column = rsp_col_ff;

endmodule

/* rtl/conv3x3_interior_filter_checker.sv */
// ----------------------------------------------------------------------------
// conv3x3_interior_filter_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_interior_filter_macros.svh"

module conv3x3_interior_filter_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input c3f_pkg::pix_type                 pixel_out,
   input logic [c3f_pkg::POS_W-1:0]        out_row,
   input logic [c3f_pkg::POS_W-1:0]        out_column
);

   // A stalled word stays up
   `C3F_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // A stalled word keeps its payload
   `C3F_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(pixel_out) && $stable(out_row) && $stable(out_column))

   // Row zero and column zero never come out
   `C3F_ASSERT(a_interior, rsp_valid |-> out_row != '0 && out_column != '0)

   // Input backs up only behind a stuck output word
   `C3F_ASSERT(a_stall_cause, !req_ready |-> rsp_valid && !rsp_ready)

   // Nothing comes out right after reset
   `C3F_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid)

endmodule

bind conv3x3_interior_filter conv3x3_interior_filter_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .pixel_out  (rsp_if.pixel_out),
   .out_row    (rsp_if.out_row),
   .out_column (rsp_if.out_column)
);

/* test/conv3x3_interior_filter_check.sv */
// ----------------------------------------------------------------------------
// conv3x3_interior_filter_check
// Watches the pixel, result and register ports of the 3x3 filter. Keeps its
// own window, line stores and counters, queues the filtered words each pixel
// should produce and compares every returned word against the oldest one.
// ----------------------------------------------------------------------------
module conv3x3_interior_filter_check
   import c3f_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   c3f_req_if                    req_mon,
   c3f_rsp_if                    rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      pix_type          pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
   } filtered_word_type;

   logic [DIM_W-1:0]      width_reg;
   logic [DIM_W-1:0]      height_reg;
   logic [CSR_DATA_W-1:0] kernel_rows [KERNEL_SIZE];

   pix_type older_line [MAX_WIDTH];
   pix_type newer_line [MAX_WIDTH];
   pix_type win [KERNEL_SIZE][KERNEL_SIZE];
   int      col_pos;
   int      row_pos;

   filtered_word_type filtered_q [$];

   function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
      if (int'(v) < MIN_DIM) begin
         return MIN_DIM;
      end else if (int'(v) > hi) begin
         return hi;
      end
      return int'(v);
   endfunction

   // Shift the window, update the line stores and queue the centre pixel
   // once the window covers three full rows and columns.
   task automatic filter_pixel(input pix_type px);
      int                w;
      int                h;
      int                c;
      int                r;
      int                sum;
      pix_type           above2;
      pix_type           above1;
      coef_type          coef;
      filtered_word_type word;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      above2 = older_line[c];
      above1 = newer_line[c];
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = above2;
      win[1][2] = above1;
      win[2][2] = px;
      older_line[c] = above1;
      newer_line[c] = px;

      if (r >= 2 && c >= 2) begin
         sum = 0;
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
               coef = coef_type'(kernel_rows[i][COEF_W*j +: COEF_W]);
               sum += int'(win[i][j]) * int'(coef);
            end
         end
         if (sum < 0) begin
            word.pixel = '0;
         end else if ((sum >>> FRAC_BITS) > PIX_MAX) begin
            word.pixel = PIX_W'(PIX_MAX);
         end else begin
            word.pixel = PIX_W'(sum >>> FRAC_BITS);
         end
         word.row    = POS_W'(r - 1);
         word.column = POS_W'(c - 1);
         filtered_q.push_back(word);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic note_fault(input bit had_word, input filtered_word_type want,
                             input filtered_word_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         if (had_word) begin
            $display("%0t: mismatch: expected pixel %0d row %0d column %0d, got pixel %0d row %0d column %0d",
                     $realtime, want.pixel, want.row, want.column,
                     got.pixel, got.row, got.column);
         end else begin
            $display("%0t: unexpected word: pixel %0d row %0d column %0d",
                     $realtime, got.pixel, got.row, got.column);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      filtered_word_type got;
      filtered_word_type want;
      if (reset) begin
         width_reg      = RST_WIDTH;
         height_reg     = RST_HEIGHT;
         kernel_rows[0] = RST_COEF_TOP;
         kernel_rows[1] = RST_COEF_MID;
         kernel_rows[2] = RST_COEF_BOT;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) win[i][j] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         filtered_q.delete();
         failures = 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WIDTH:    width_reg      = csr_wdata[DIM_W-1:0];
               CSR_HEIGHT:   height_reg     = csr_wdata[DIM_W-1:0];
               CSR_COEF_TOP: kernel_rows[0] = csr_wdata;
               CSR_COEF_MID: kernel_rows[1] = csr_wdata;
               CSR_COEF_BOT: kernel_rows[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) filter_pixel(req_mon.pixel_in);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pixel  = rsp_mon.pixel_out;
            got.row    = rsp_mon.out_row;
            got.column = rsp_mon.out_column;
            if (filtered_q.size() == 0) begin
               note_fault(1'b0, got, got);
            end else begin
               want = filtered_q.pop_front();
               if (got.pixel !== want.pixel || got.row !== want.row ||
                   got.column !== want.column) begin
                  note_fault(1'b1, want, got);
               end
            end
         end
         pending <= filtered_q.size();
      end
   end

endmodule

/* test/conv3x3_interior_filter_test.sv */
// ----------------------------------------------------------------------------
// conv3x3_interior_filter_test
// Streams grey frames into the 3x3 filter: a few directed frames on the
// smallest size with identity, full positive and full negative kernels, then
// random sizes, kernels and mid-frame size changes, plus one frame that starts
// at the widest and one that starts at the tallest size, each cut short by a
// resize. Both handshakes idle at random; a separate checker predicts and
// compares every filtered word.
// ----------------------------------------------------------------------------
module conv3x3_interior_filter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import c3f_pkg::*;

   localparam int  SETTLE_CYCLES = 12;
   localparam int  TAIL_CYCLES   = 20;
   localparam int  RANDOM_ITEMS  = 400;
   localparam int  WIDE_PREFIX   = 100;
   localparam int  TALL_PREFIX   = 120;
   localparam real RUN_LIMIT_NS  = 100_000_000.0;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   localparam coef_type COEF_MAX = 16'sh7FFF;
   localparam coef_type COEF_MIN = 16'sh8000;

   localparam pix_type CROSS_FRAME [9] = '{8'h00, 8'hFF, 8'h00,
                                          8'hFF, 8'hA5, 8'hFF,
                                          8'h00, 8'hFF, 8'h00};

   typedef enum int {KERNEL_FIXED, KERNEL_RANDOM, KERNEL_BLUR, KERNEL_MIXED}
      kernel_style_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    failures;
   int                    pending;

   bit                    steady;
   logic [DIM_W-1:0]      width_raw;
   logic [DIM_W-1:0]      height_raw;
   int                    col_at;
   int                    row_at;
   int                    pixels_sent;

   c3f_req_if req_ch ();
   c3f_rsp_if rsp_ch ();

   conv3x3_interior_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   conv3x3_interior_filter_check filter_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic pix_type pick_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PIX_W'($urandom_range(0, PIX_MAX));
   endfunction

   function automatic coef_type pick_coef(input kernel_style_type style,
                                          input coef_type fixed);
      case (style)
         KERNEL_RANDOM: return coef_type'($urandom);
         KERNEL_BLUR:   return coef_type'(226 + $urandom_range(0, 3));
         KERNEL_MIXED:  return coef_type'(int'($urandom_range(0, 3000)) - 1500);
         default:       return fixed;
      endcase
   endfunction

   function automatic int dim_of(input logic [DIM_W-1:0] v, input int hi);
      if (int'(v) < MIN_DIM) return MIN_DIM;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // Dimension in the low bits, junk above that the block must ignore
   function automatic logic [CSR_DATA_W-1:0] dim_word(input int v);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'({$urandom, $urandom});
      word[DIM_W-1:0] = DIM_W'(v);
      return word;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_WIDTH) width_raw = data[DIM_W-1:0];
      if (idx == CSR_HEIGHT) height_raw = data[DIM_W-1:0];
   endtask

   task automatic write_kernel(input kernel_style_type style, input coef_type fixed);
      write_reg(CSR_COEF_TOP, {pick_coef(style, fixed), pick_coef(style, fixed),
                               pick_coef(style, fixed)});
      write_reg(CSR_COEF_MID, {pick_coef(style, fixed), pick_coef(style, fixed),
                               pick_coef(style, fixed)});
      write_reg(CSR_COEF_BOT, {pick_coef(style, fixed), pick_coef(style, fixed),
                               pick_coef(style, fixed)});
   endtask

   // Track where the next pixel lands in the frame
   task automatic advance_position();
      int w;
      int h;
      w = dim_of(width_raw, MAX_WIDTH);
      h = dim_of(height_raw, MAX_HEIGHT);
      if (col_at >= w) begin
         col_at = 0;
         row_at++;
      end
      if (row_at >= h) row_at = 0;
      col_at++;
      if (col_at >= w) begin
         col_at = 0;
         row_at++;
         if (row_at >= h) row_at = 0;
      end
   endtask

   task automatic send_pixel(input pix_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= px;
      do @(posedge clock); while (!req_ch.ready);
      advance_position();
      pixels_sent++;
   endtask

   // Hold the input until every queued word has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic settle_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic finish_frame();
      while (!(col_at == 0 && row_at == 0)) begin
         send_pixel(pick_pixel());
         if ($urandom_range(0, 59) == 0) drain_results();
      end
   endtask

   // Result sink: ready runs of random length between random stalls
   initial begin : result_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int  small_items;
      int  start_count;
      int  total;
      int  cut;
      int  w;
      bit  wide_done;
      bit  tall_done;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.pixel_in <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      width_raw   = RST_WIDTH;
      height_raw  = RST_HEIGHT;
      col_at      = 0;
      row_at      = 0;
      pixels_sent = 0;
      steady      = 1'b0;
      small_items = 0;
      wide_done   = 1'b0;
      tall_done   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Below the minimum: both dimensions saturate to three; reset kernel
      write_reg(CSR_WIDTH, dim_word(0));
      write_reg(CSR_HEIGHT, dim_word(2));
      write_reg(CSR_UNUSED_HI, '1);
      foreach (CROSS_FRAME[i]) send_pixel(CROSS_FRAME[i]);

      // Largest positive kernel saturates at white; pause mid-frame
      settle_idle();
      write_kernel(KERNEL_FIXED, COEF_MAX);
      repeat (5) send_pixel('1);
      drain_results();
      repeat (4) send_pixel('1);

      // Most negative kernel drives the sum below zero
      settle_idle();
      write_kernel(KERNEL_FIXED, COEF_MIN);
      repeat (9) send_pixel('1);

      while (small_items < RANDOM_ITEMS) begin
         settle_idle();
         steady = ($urandom_range(0, 4) == 0);
         if (!wide_done && small_items >= 130) begin
            // Saturated width; narrow it partway through the first row
            start_count = pixels_sent;
            write_reg(CSR_WIDTH, dim_word(8191));
            write_reg(CSR_HEIGHT, dim_word(3));
            write_kernel(kernel_style_type'($urandom_range(int'(KERNEL_BLUR),
                                                           int'(KERNEL_MIXED))), '0);
            repeat (WIDE_PREFIX) send_pixel(pick_pixel());
            settle_idle();
            write_reg(CSR_WIDTH, dim_word($urandom_range(MIN_DIM, 12)));
            finish_frame();
            small_items += pixels_sent - start_count;
            wide_done = 1'b1;
         end else if (!tall_done && small_items >= 260) begin
            // Tallest frame; lower the height after some rows to wrap early
            start_count = pixels_sent;
            write_reg(CSR_WIDTH, dim_word(3));
            write_reg(CSR_HEIGHT, dim_word(MAX_HEIGHT));
            write_kernel(kernel_style_type'($urandom_range(int'(KERNEL_BLUR),
                                                           int'(KERNEL_MIXED))), '0);
            repeat (TALL_PREFIX) send_pixel(pick_pixel());
            settle_idle();
            write_reg(CSR_HEIGHT, dim_word($urandom_range(MIN_DIM, 8)));
            finish_frame();
            small_items += pixels_sent - start_count;
            tall_done = 1'b1;
         end else begin
            start_count = pixels_sent;
            case ($urandom_range(0, 9))
               0:       w = $urandom_range(0, 2);
               1, 2:    w = $urandom_range(13, 40);
               default: w = $urandom_range(3, 12);
            endcase
            write_reg(CSR_WIDTH, dim_word(w));
            write_reg(CSR_HEIGHT, dim_word(($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, 2) : $urandom_range(3, 8)));
            if ($urandom_range(0, 3) != 0) begin
               write_kernel(kernel_style_type'($urandom_range(int'(KERNEL_RANDOM),
                                                              int'(KERNEL_MIXED))), '0);
            end
            if ($urandom_range(0, 3) == 0) begin
               write_reg(CSR_IDX_W'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                         CSR_DATA_W'({$urandom, $urandom}));
            end
            total = dim_of(width_raw, MAX_WIDTH) * dim_of(height_raw, MAX_HEIGHT) *
                    $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0) begin
               // Resize mid-frame: shrink the width or move the height
               cut = $urandom_range(1, total - 1);
               repeat (cut) send_pixel(pick_pixel());
               settle_idle();
               if ($urandom_range(0, 1) == 1 && dim_of(width_raw, MAX_WIDTH) > MIN_DIM) begin
                  write_reg(CSR_WIDTH,
                            dim_word($urandom_range(MIN_DIM, dim_of(width_raw, MAX_WIDTH) - 1)));
               end else begin
                  write_reg(CSR_HEIGHT, dim_word($urandom_range(MIN_DIM, 8)));
               end
            end else begin
               repeat (total) begin
                  send_pixel(pick_pixel());
                  if ($urandom_range(0, 59) == 0) drain_results();
               end
            end
            finish_frame();
            small_items += pixels_sent - start_count;
         end
      end

      settle_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("conv3x3_interior_filter_test OK");
      end else begin
         $display("conv3x3_interior_filter_test NOT OK");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("conv3x3_interior_filter_test NOT OK");
      $finish;
   end

endmodule
